>>> hw/rtl/enot_pkg.sv
// Shared types and constants for the extent node offset translator.
// Used by enot_div, enot_ctrl, enot_dpath and the top level; no dependencies.
`timescale 1ns / 1ps

package enot_pkg;

  // Item command codes
  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_SIZE     = 2'd2;

  // Configuration reset values
  localparam logic [31:0] BLOCK_SIZE_RST = 32'd4096;
  localparam logic [15:0] NODE_SIZE_RST  = 16'd4096;

  // Iterative divider geometry: 64-bit dividend, 16-bit divisor
  localparam int DIVIDEND_W   = 64;
  localparam int DIVISOR_W    = 16;
  localparam int DIV_BITS     = 8;
  localparam int DIV_CYCLES   = DIVIDEND_W / DIV_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_OFF_MUL1,
    ST_OFF_MUL2,
    ST_OFF_SUM,
    ST_HIT_OUT,
    ST_MISS_OUT
  } enot_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;   // write extent slot from the input item
    logic start_walk;  // capture node number, clear walk state
    logic cap_mul;     // prod = count[idx] * block_size
    logic div_start;   // start capacity division of prod
    logic step_slot;   // nodes_prior += capacity, advance slot
    logic off_mul1;    // prod = start[idx] * block_size
    logic off_mul2;    // acc = volume_offset + prod, prod = rel * node_size
    logic off_sum;     // acc = acc + prod
    logic set_result;  // load output register
    logic res_found;   // found flag for the output register
  } enot_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic hit;
    logic last_slot;
  } enot_stat_t;

endpackage

>>> hw/rtl/enot_div.sv
// Iterative unsigned divider, 64-bit dividend by 16-bit divisor, 8 quotient
// bits per cycle. Depends on enot_pkg for its geometry.
`timescale 1ns / 1ps

module enot_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [enot_pkg::DIVIDEND_W-1:0]      dividend,
  input  logic [enot_pkg::DIVISOR_W-1:0]       divisor,
  output logic [enot_pkg::DIVIDEND_W-1:0]      quotient,
  output logic                                 done
);

  logic [enot_pkg::DIVIDEND_W-1:0] work;
  logic [enot_pkg::DIVIDEND_W-1:0] work_next;
  logic [enot_pkg::DIVISOR_W-1:0]  rem;
  logic [enot_pkg::DIVISOR_W-1:0]  rem_next;
  logic [enot_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            busy;

  // Eight restoring steps; quotient bits shift into the low end of work
  always_comb begin
    logic [enot_pkg::DIVISOR_W:0] trial;
    work_next = work;
    rem_next  = rem;
    for (int i = 0; i < enot_pkg::DIV_BITS; i++) begin
      trial = {rem_next, work_next[enot_pkg::DIVIDEND_W-1]};
      work_next = {work_next[enot_pkg::DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next     = enot_pkg::DIVISOR_W'(trial - {1'b0, divisor});
        work_next[0] = 1'b1;
      end else begin
        rem_next = trial[enot_pkg::DIVISOR_W-1:0];
      end
    end
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == enot_pkg::DIV_CNT_W'(enot_pkg::DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

>>> hw/rtl/enot_ctrl.sv
// Controller state machine for the extent node offset translator: sequences
// the extent walk and owns the handshakes. Depends on enot_pkg.
`timescale 1ns / 1ps

module enot_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  enot_pkg::enot_stat_t stat,
  output enot_pkg::enot_ctrl_t ctl
);

  enot_pkg::enot_state_t state;
  enot_pkg::enot_state_t state_next;
  logic                  accept;
  logic                  out_free;

  assign req_ready = (state == enot_pkg::ST_IDLE);
  assign accept    = req_valid & req_ready;
  assign out_free  = ~rsp_valid | rsp_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      enot_pkg::ST_IDLE: begin
        if (accept && cmd == enot_pkg::CMD_TRANSLATE) state_next = enot_pkg::ST_CAP_MUL;
      end
      enot_pkg::ST_CAP_MUL:  state_next = enot_pkg::ST_DIV_GO;
      enot_pkg::ST_DIV_GO:   state_next = enot_pkg::ST_DIV_WAIT;
      enot_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) state_next = enot_pkg::ST_CHECK;
      end
      enot_pkg::ST_CHECK: begin
        priority if (stat.hit)  state_next = enot_pkg::ST_OFF_MUL1;
        else if (stat.last_slot) state_next = enot_pkg::ST_MISS_OUT;
        else                     state_next = enot_pkg::ST_CAP_MUL;
      end
      enot_pkg::ST_OFF_MUL1: state_next = enot_pkg::ST_OFF_MUL2;
      enot_pkg::ST_OFF_MUL2: state_next = enot_pkg::ST_OFF_SUM;
      enot_pkg::ST_OFF_SUM:  state_next = enot_pkg::ST_HIT_OUT;
      enot_pkg::ST_HIT_OUT, enot_pkg::ST_MISS_OUT: begin
        if (out_free) state_next = enot_pkg::ST_IDLE;
      end
      default: state_next = enot_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl = '0;
    unique case (state)
      enot_pkg::ST_IDLE: begin
        ctl.load_item  = accept & (cmd == enot_pkg::CMD_LOAD);
        ctl.start_walk = accept & (cmd == enot_pkg::CMD_TRANSLATE);
      end
      enot_pkg::ST_CAP_MUL:  ctl.cap_mul   = 1'b1;
      enot_pkg::ST_DIV_GO:   ctl.div_start = 1'b1;
      enot_pkg::ST_DIV_WAIT: ctl = '0;
      enot_pkg::ST_CHECK:    ctl.step_slot = ~stat.hit & ~stat.last_slot;
      enot_pkg::ST_OFF_MUL1: ctl.off_mul1  = 1'b1;
      enot_pkg::ST_OFF_MUL2: ctl.off_mul2  = 1'b1;
      enot_pkg::ST_OFF_SUM:  ctl.off_sum   = 1'b1;
      enot_pkg::ST_HIT_OUT: begin
        ctl.set_result = out_free;
        ctl.res_found  = 1'b1;
      end
      enot_pkg::ST_MISS_OUT: ctl.set_result = out_free;
      default: ctl = '0;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= enot_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.set_result) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/enot_dpath.sv
// Datapath for the extent node offset translator: config registers, extent
// tables, shared multiplier, walk registers and result register.
// Depends on enot_pkg and enot_div.
`timescale 1ns / 1ps

module enot_dpath #(
  parameter int EXTENT_SLOTS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [enot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                        cfg_data,
  input  logic [2:0]                         slot_index,
  input  logic [31:0]                        start_block,
  input  logic [31:0]                        block_count,
  input  logic [31:0]                        node_number,
  input  enot_pkg::enot_ctrl_t               ctl,
  output enot_pkg::enot_stat_t               stat,
  output logic [63:0]                        byte_offset,
  output logic                               found
);

  localparam int IDX_W = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;

  logic [63:0]      volume_offset;
  logic [31:0]      block_size;
  logic [15:0]      node_size;
  logic [31:0]      start_tab [EXTENT_SLOTS];
  logic [31:0]      count_tab [EXTENT_SLOTS];
  logic [IDX_W-1:0] idx;
  logic [31:0]      node;
  logic [31:0]      nodes_prior;
  logic [31:0]      rel;
  logic [63:0]      prod;
  logic [63:0]      acc;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [63:0]      quotient;
  logic [63:0]      cap;
  logic             div_done;
  logic             slot_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_offset <= '0;
      block_size    <= enot_pkg::BLOCK_SIZE_RST;
      node_size     <= enot_pkg::NODE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        enot_pkg::CFG_VOLUME_OFFSET: volume_offset <= cfg_data;
        enot_pkg::CFG_BLOCK_SIZE:    block_size    <= cfg_data[31:0];
        enot_pkg::CFG_NODE_SIZE:     node_size     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Extent tables; loads beyond the table are dropped
  assign slot_ok = (int'(slot_index) < EXTENT_SLOTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EXTENT_SLOTS; i++) begin
        start_tab[i] <= '0;
        count_tab[i] <= '0;
      end
    end else if (ctl.load_item && slot_ok) begin
      start_tab[IDX_W'(slot_index)] <= start_block;
      count_tab[IDX_W'(slot_index)] <= block_count;
    end
  end

  // Shared 32x32 multiplier operand select
  always_comb begin
    mul_a = count_tab[idx];
    mul_b = block_size;
    priority if (ctl.off_mul1) begin
      mul_a = start_tab[idx];
    end else if (ctl.off_mul2) begin
      mul_a = rel;
      mul_b = {16'd0, node_size};
    end else begin
      mul_a = count_tab[idx];
    end
  end

  assign mul_p = mul_a * mul_b;

  // Capacity of the current extent in nodes
  enot_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (prod),
    .divisor  (node_size),
    .quotient (quotient),
    .done     (div_done)
  );

  assign cap = (node_size == 16'd0) ? 64'd0 : quotient;
  // nodes_prior never passes node, so this cannot wrap
  assign rel = node - nodes_prior;

  assign stat.div_done  = div_done;
  // node zero is the header node of the first extent
  assign stat.hit       = (node == 32'd0) || ({32'd0, rel} < cap);
  assign stat.last_slot = (idx == IDX_W'(EXTENT_SLOTS - 1));

  // Walk and offset registers
  always_ff @(posedge clk) begin
    if (ctl.start_walk) begin
      node        <= node_number;
      nodes_prior <= '0;
      idx         <= '0;
    end else if (ctl.step_slot) begin
      nodes_prior <= nodes_prior + cap[31:0];
      idx         <= idx + 1'b1;
    end
    if (ctl.cap_mul || ctl.off_mul1 || ctl.off_mul2) prod <= mul_p;
    if (ctl.off_mul2) acc <= volume_offset + prod;
    else if (ctl.off_sum) acc <= acc + prod;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.set_result) begin
      byte_offset <= ctl.res_found ? acc : 64'd0;
      found       <= ctl.res_found;
    end
  end

endmodule

>>> hw/rtl/extent_node_offset_translate_top.sv
// Top level of the extent node offset translator.
// Instantiates enot_ctrl and enot_dpath; depends on enot_pkg.
`timescale 1ns / 1ps

// Translates a B-tree node number into a byte offset through a table of
// EXTENT_SLOTS extents. A load item (cmd 0) writes one slot and returns
// nothing. A translate item (cmd 1) walks the slots in order, computing each
// extent's node capacity with an iterative divider that yields 8 quotient
// bits per cycle; each slot visited takes a multiply, a divide plus handoff
// and a compare. A miss returns byte_offset 0 with found 0. Node 0 always
// maps to the start of the first extent. The result sits in an output
// register, so the next item is taken while it waits. Configuration writes
// take effect at once and are meant for idle periods.
module extent_node_offset_translate_top #(
  parameter int EXTENT_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        cmd,
  input  logic [2:0]  slot_index,
  input  logic [31:0] start_block,
  input  logic [31:0] block_count,
  input  logic [31:0] node_number,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [63:0] byte_offset,
  output logic        found
);

  enot_pkg::enot_ctrl_t ctl;
  enot_pkg::enot_stat_t stat;

  // Sequencer
  enot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Tables and arithmetic
  enot_dpath #(
    .EXTENT_SLOTS (EXTENT_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .slot_index  (slot_index),
    .start_block (start_block),
    .block_count (block_count),
    .node_number (node_number),
    .ctl         (ctl),
    .stat        (stat),
    .byte_offset (byte_offset),
    .found       (found)
  );

endmodule
